/* hdl/clc_pkg.sv */
// Shared types, token codes and word tables for the column line classifier.
// No dependencies; every other file in hdl/ refers to this package by scoped names.
`default_nettype none

package clc_pkg;

    // Token codes on the result stream.
    localparam logic [3:0] K_SPEC_H  = 4'd0;
    localparam logic [3:0] K_SPEC_F  = 4'd1;
    localparam logic [3:0] K_SPEC_D  = 4'd2;
    localparam logic [3:0] K_SPEC_C  = 4'd3;
    localparam logic [3:0] K_SPEC_P  = 4'd4;
    localparam logic [3:0] K_COMMENT = 4'd5;
    localparam logic [3:0] K_COPY    = 4'd6;
    localparam logic [3:0] K_STAR    = 4'd7;
    localparam logic [3:0] K_UNKNOWN = 4'd8;
    localparam logic [3:0] K_NEWLINE = 4'd9;
    localparam logic [3:0] K_FREE    = 4'd10;

    // Directive word handling phases.
    localparam logic [1:0] PH_DECIDE = 2'd0;
    localparam logic [1:0] PH_SPACE  = 2'd1;
    localparam logic [1:0] PH_WORD   = 2'd2;
    localparam logic [1:0] PH_DONE   = 2'd3;

    // Column of the spec letter, counted from zero, and the longest directive word.
    localparam logic [2:0] SEQ_COLS  = 3'd5;
    localparam logic [3:0] MAX_WORD  = 4'd8;
    localparam logic [3:0] LEN_COPY  = 4'd4;
    localparam logic [3:0] LEN_INCL  = 4'd7;

    // Characters with a meaning of their own.
    localparam logic [7:0] CH_STAR   = 8'h2a;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_LF     = 8'h0a;

    // Depth of the result queue.
    localparam int unsigned QDEPTH   = 8;
    localparam int unsigned QAW      = $clog2(QDEPTH);

    typedef struct packed {
        logic [3:0] kind;
        logic       last;
    } t_result;

    // Results produced by one input word: zero, one or two.
    typedef struct packed {
        logic [1:0] cnt;
        t_result    r0;
        t_result    r1;
    } t_push;

    // Letters of "copy", lower case.
    function automatic logic [7:0] copy_letter(input logic [1:0] n);
        logic [7:0] c;
        case (n)
            2'd0:    c = 8'h63;
            2'd1:    c = 8'h6f;
            2'd2:    c = 8'h70;
            default: c = 8'h79;
        endcase
        return c;
    endfunction

    // Letters of "include", lower case; the eighth slot matches nothing.
    function automatic logic [7:0] incl_letter(input logic [2:0] n);
        logic [7:0] c;
        case (n)
            3'd0:    c = 8'h69;
            3'd1:    c = 8'h6e;
            3'd2:    c = 8'h63;
            3'd3:    c = 8'h6c;
            3'd4:    c = 8'h75;
            3'd5:    c = 8'h64;
            3'd6:    c = 8'h65;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

/* hdl/clc_line_fsm.sv */
// Per-line state of the classifier and the logic that turns one byte into results.
// Depends on clc_pkg for token codes, phases and the directive word tables.
`default_nettype none

module clc_line_fsm (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [7:0]    i_char,
    input  wire logic          i_eoi,
    output clc_pkg::t_push     o_push
);

    logic       r_free;
    logic [2:0] r_col;
    logic [3:0] r_pending;
    logic [3:0] r_letters;
    logic [1:0] r_phase;
    logic [1:0] r_flags;
    logic       r_cr;
    logic       r_star1;

    logic       n_free;
    logic [2:0] n_col;
    logic [3:0] n_pending;
    logic [3:0] n_letters;
    logic [1:0] n_phase;
    logic [1:0] n_flags;
    logic       n_cr;
    logic       n_star1;

    logic [7:0] lc;
    logic [3:0] word_class;
    logic [3:0] line_class;
    logic       is_letter;

    // Lower-case copy of the byte and the class a finished directive word gives.
    always_comb begin
        lc = i_char;
        if (i_char inside {[8'h41:8'h5a]}) begin
            lc = i_char + 8'h20;
        end
        is_letter = lc inside {[8'h61:8'h7a]};
        if ((r_flags[0] && r_letters == clc_pkg::LEN_COPY) ||
            (r_flags[1] && r_letters == clc_pkg::LEN_INCL)) begin
            word_class = clc_pkg::K_COPY;
        end else begin
            word_class = clc_pkg::K_UNKNOWN;
        end
        line_class = (r_phase == clc_pkg::PH_WORD) ? word_class : r_pending;
    end

    // Next state and results for the byte in the input register.
    always_comb begin
        n_free    = r_free;
        n_col     = r_col;
        n_pending = r_pending;
        n_letters = r_letters;
        n_phase   = r_phase;
        n_flags   = r_flags;
        n_cr      = r_cr;
        n_star1   = r_star1;
        o_push    = '0;

        if (!i_valid) begin
            o_push.cnt = 2'd0;
        end else if (i_eoi) begin
            // End of input flushes a partial line without a newline.
            if (r_col != 3'd0) begin
                o_push.cnt     = 2'd1;
                o_push.r0.kind = line_class;
                o_push.r0.last = 1'b1;
            end
            n_col     = 3'd0;
            n_pending = clc_pkg::K_UNKNOWN;
            n_letters = 4'd0;
            n_phase   = clc_pkg::PH_DECIDE;
            n_flags   = 2'b11;
            n_star1   = 1'b0;
            n_free    = 1'b0;
            n_cr      = 1'b0;
        end else if (i_char == clc_pkg::CH_LF && r_cr) begin
            // Line feed after a carriage return is part of the same newline.
            n_cr = 1'b0;
        end else if (i_char == clc_pkg::CH_LF || i_char == clc_pkg::CH_CR) begin
            n_cr = (i_char == clc_pkg::CH_CR);
            if (r_col != 3'd0) begin
                if (line_class == clc_pkg::K_STAR) begin
                    n_free = 1'b1;
                end
                o_push.cnt     = 2'd2;
                o_push.r0.kind = line_class;
                o_push.r0.last = 1'b0;
                o_push.r1.kind = clc_pkg::K_NEWLINE;
                o_push.r1.last = 1'b1;
            end else begin
                o_push.cnt     = 2'd1;
                o_push.r0.kind = clc_pkg::K_NEWLINE;
                o_push.r0.last = 1'b1;
            end
            n_col     = 3'd0;
            n_pending = clc_pkg::K_UNKNOWN;
            n_letters = 4'd0;
            n_phase   = clc_pkg::PH_DECIDE;
            n_flags   = 2'b11;
            n_star1   = 1'b0;
        end else begin
            n_cr = 1'b0;
            if (r_col == 3'd0) begin
                // First column: a star may open a star directive.
                n_pending = r_free ? clc_pkg::K_FREE : clc_pkg::K_UNKNOWN;
                if (i_char == clc_pkg::CH_STAR) begin
                    n_star1 = 1'b1;
                    n_phase = clc_pkg::PH_DONE;
                end
            end else if (r_star1 && r_col == 3'd1) begin
                if (i_char == clc_pkg::CH_STAR) begin
                    n_pending = clc_pkg::K_STAR;
                end
            end else if (!r_free && !r_star1) begin
                case (r_phase)
                    clc_pkg::PH_DECIDE: begin
                        // Spec column decides the line.
                        if (r_col == clc_pkg::SEQ_COLS) begin
                            n_phase = clc_pkg::PH_DONE;
                            case (lc)
                                8'h68:             n_pending = clc_pkg::K_SPEC_H;
                                8'h66:             n_pending = clc_pkg::K_SPEC_F;
                                8'h64:             n_pending = clc_pkg::K_SPEC_D;
                                8'h63:             n_pending = clc_pkg::K_SPEC_C;
                                8'h70:             n_pending = clc_pkg::K_SPEC_P;
                                clc_pkg::CH_STAR:  n_pending = clc_pkg::K_COMMENT;
                                clc_pkg::CH_SLASH: begin
                                    n_phase   = clc_pkg::PH_WORD;
                                    n_letters = 4'd0;
                                    n_flags   = 2'b11;
                                end
                                clc_pkg::CH_SPACE: n_phase = clc_pkg::PH_SPACE;
                                default:           n_pending = clc_pkg::K_UNKNOWN;
                            endcase
                        end
                    end
                    clc_pkg::PH_SPACE: begin
                        // Blank spec column: the next column decides.
                        n_phase = clc_pkg::PH_DONE;
                        if (i_char == clc_pkg::CH_STAR) begin
                            n_pending = clc_pkg::K_COMMENT;
                        end else if (i_char == clc_pkg::CH_SLASH) begin
                            n_phase   = clc_pkg::PH_WORD;
                            n_letters = 4'd0;
                            n_flags   = 2'b11;
                        end else begin
                            n_pending = clc_pkg::K_UNKNOWN;
                        end
                    end
                    clc_pkg::PH_WORD: begin
                        // Match the directive word one letter at a time.
                        if (is_letter && r_letters < clc_pkg::MAX_WORD) begin
                            if (!(r_letters < clc_pkg::LEN_COPY &&
                                  clc_pkg::copy_letter(r_letters[1:0]) == lc)) begin
                                n_flags[0] = 1'b0;
                            end
                            if (!(r_letters < clc_pkg::LEN_INCL &&
                                  clc_pkg::incl_letter(r_letters[2:0]) == lc)) begin
                                n_flags[1] = 1'b0;
                            end
                            n_letters = r_letters + 4'd1;
                        end else begin
                            n_pending = word_class;
                            n_phase   = clc_pkg::PH_DONE;
                        end
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end
            if (r_col != 3'd7) begin
                n_col = r_col + 3'd1;
            end
        end
    end

    // Line state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free    <= 1'b0;
            r_col     <= 3'd0;
            r_pending <= clc_pkg::K_UNKNOWN;
            r_letters <= 4'd0;
            r_phase   <= clc_pkg::PH_DECIDE;
            r_flags   <= 2'b11;
            r_cr      <= 1'b0;
            r_star1   <= 1'b0;
        end else begin
            r_free    <= n_free;
            r_col     <= n_col;
            r_pending <= n_pending;
            r_letters <= n_letters;
            r_phase   <= n_phase;
            r_flags   <= n_flags;
            r_cr      <= n_cr;
            r_star1   <= n_star1;
        end
    end

endmodule

`default_nettype wire

/* hdl/clc_out_fifo.sv */
// Small result queue that takes up to two results a cycle and hands out one.
// Depends on clc_pkg for the result type and the queue depth.
`default_nettype none

module clc_out_fifo (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  clc_pkg::t_push             i_push,
    input  wire logic                  i_pop,
    output logic                       o_valid,
    output clc_pkg::t_result           o_data,
    output logic [clc_pkg::QAW:0]      o_count
);

    clc_pkg::t_result            r_mem [clc_pkg::QDEPTH];
    logic [clc_pkg::QAW-1:0]     r_wp;
    logic [clc_pkg::QAW-1:0]     r_rp;
    logic [clc_pkg::QAW:0]       r_count;
    logic                        pop_ok;
    logic [clc_pkg::QAW-1:0]     wp1;

    assign pop_ok  = i_pop && (r_count != '0);
    assign wp1     = r_wp + 1'b1;
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rp];
    assign o_count = r_count;

    // Storage; the second result goes in the slot after the first.
    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wp] <= i_push.r0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[wp1] <= i_push.r1;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= r_wp + clc_pkg::QAW'(i_push.cnt);
            r_rp    <= r_rp + clc_pkg::QAW'(pop_ok);
            r_count <= r_count + (clc_pkg::QAW + 1)'(i_push.cnt)
                       - (clc_pkg::QAW + 1)'(pop_ok);
        end
    end

endmodule

`default_nettype wire

/* hdl/column_line_classifier.sv */
// Top level of the column line classifier: input register, line logic, result queue.
// Depends on clc_pkg, clc_line_fsm and clc_out_fifo.
`default_nettype none

// Bytes enter on the s_ stream one per cycle: a byte is registered, classified in the
// next cycle, and any results land in an eight-entry queue that feeds the m_ stream.
// A byte that ends no line gives no result; a line end gives the line class and a
// newline token (or the newline alone for an empty line), with tlast on the final one.
// End of input is a word with s_tuser set. Input is taken every cycle as long as the
// queue has room for the results of the byte in flight and of the new one, so the
// block runs at one byte per cycle; only a slow or stalled result side holds it back,
// at one result per cycle out.
module column_line_classifier (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] char_code
    input  wire logic       s_tuser,   // [0] end_of_input
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [3:0] token_kind, [7:4] zero
    output logic            m_tlast    // last_of_run
);

    logic                      r_in_valid;
    logic [7:0]                r_in_char;
    logic                      r_in_eoi;
    clc_pkg::t_push            push;
    clc_pkg::t_result          head;
    logic [clc_pkg::QAW:0]     q_count;
    logic [clc_pkg::QAW+1:0]   q_need;
    logic                      s_acc;

    // Room for the word in the input register and a new word, two results each.
    assign q_need   = (clc_pkg::QAW + 2)'(q_count)
                    + (r_in_valid ? (clc_pkg::QAW + 2)'(2) : '0)
                    + (clc_pkg::QAW + 2)'(2);
    assign s_tready = (q_need <= (clc_pkg::QAW + 2)'(clc_pkg::QDEPTH));
    assign s_acc    = s_tvalid && s_tready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= s_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_in_char <= s_tdata;
            r_in_eoi  <= s_tuser;
        end
    end

    clc_line_fsm u_line (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .i_char  (r_in_char),
        .i_eoi   (r_in_eoi),
        .o_push  (push)
    );

    clc_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (m_tready),
        .o_valid (m_tvalid),
        .o_data  (head),
        .o_count (q_count)
    );

    assign m_tdata = {4'd0, head.kind};
    assign m_tlast = head.last;

    // The queue never overfills.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= (clc_pkg::QAW + 1)'(clc_pkg::QDEPTH))
        else $error("result queue overfilled");

    // An accepted word is in the input register on the next cycle.
    a_in_reg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> r_in_valid)
        else $error("accepted word lost before the input register");

    // Results come only from a word in the input register.
    a_push_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.cnt != 2'd0) |-> r_in_valid)
        else $error("result produced with no word in flight");

endmodule

`default_nettype wire
